/* rtl/stcr_pkg.sv */
// Shared types and constants for the servo turnout ramp controller.
// No dependencies; compiled first.
`default_nettype none

package stcr_pkg;

	// Field widths
	localparam int unsigned FUNC_W  = 13;
	localparam int unsigned FIDX_W  = 4;
	localparam int unsigned PULSE_W = 12;
	localparam int unsigned STEP_W  = 16;
	localparam int unsigned FRAC_W  = 8;
	localparam int unsigned POS_W   = PULSE_W + FRAC_W;
	localparam int unsigned CIDX_W  = 3;
	localparam int unsigned CDATA_W = 16;

	// Highest function bit that can be selected
	localparam logic [FIDX_W-1:0] FUNC_IDX_MAX = 4'd12;

	// Configuration register indexes
	localparam logic [CIDX_W-1:0] REG_FUNCTION_INDEX  = 3'd0;
	localparam logic [CIDX_W-1:0] REG_SAVED_DIRECTION = 3'd1;
	localparam logic [CIDX_W-1:0] REG_OFF_PULSE_US    = 3'd2;
	localparam logic [CIDX_W-1:0] REG_ON_PULSE_US     = 3'd3;
	localparam logic [CIDX_W-1:0] REG_OFF_STEP        = 3'd4;
	localparam logic [CIDX_W-1:0] REG_ON_STEP         = 3'd5;

	// Reset values of the configuration registers
	localparam logic [PULSE_W-1:0] OFF_PULSE_RST = 12'd1000;
	localparam logic [PULSE_W-1:0] ON_PULSE_RST  = 12'd2000;
	localparam logic [STEP_W-1:0]  OFF_STEP_RST  = 16'd2560;
	localparam logic [STEP_W-1:0]  ON_STEP_RST   = 16'd2560;

	typedef enum logic [1:0] {
		PH_STANDBY = 2'd0,
		PH_IDLE    = 2'd1,
		PH_RUN     = 2'd2
	} phase_t;

	typedef struct packed {
		logic [FIDX_W-1:0]  function_index;
		logic               saved_direction;
		logic [PULSE_W-1:0] off_pulse_us;
		logic [PULSE_W-1:0] on_pulse_us;
		logic [STEP_W-1:0]  off_step;
		logic [STEP_W-1:0]  on_step;
	} cfg_t;

	typedef struct packed {
		logic [PULSE_W-1:0] pulse_us;
		logic               pulse_write;
		logic               servo_attached;
		logic               save_event;
		logic               save_value;
		logic               led_on_side;
		phase_t             phase;
	} result_t;

endpackage

`default_nettype wire

/* rtl/stcr_in_if.sv */
// Request channel of the servo turnout ramp controller: valid/ready plus function bits.
// Depends on stcr_pkg.
`default_nettype none

interface stcr_in_if;
	logic                          valid;
	logic                          ready;
	logic [stcr_pkg::FUNC_W-1:0]   function_bits;

	modport source (output valid, output function_bits, input ready);
	modport sink (input valid, input function_bits, output ready);
endinterface

`default_nettype wire

/* rtl/stcr_out_if.sv */
// Result channel of the servo turnout ramp controller: valid/ready plus result fields.
// Depends on stcr_pkg.
`default_nettype none

interface stcr_out_if;
	logic                          valid;
	logic                          ready;
	logic [stcr_pkg::PULSE_W-1:0]  pulse_us;
	logic                          pulse_write;
	logic                          servo_attached;
	logic                          save_event;
	logic                          save_value;
	logic                          led_on_side;
	logic [1:0]                    phase;

	modport source (output valid, output pulse_us, output pulse_write, output servo_attached,
		output save_event, output save_value, output led_on_side, output phase, input ready);
	modport sink (input valid, input pulse_us, input pulse_write, input servo_attached,
		input save_event, input save_value, input led_on_side, input phase, output ready);
endinterface

`default_nettype wire

/* rtl/stcr_cfg_regs.sv */
// Configuration register file for the servo turnout ramp controller.
// Depends on stcr_pkg.
`default_nettype none

module stcr_cfg_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         wr_en,
	input  wire logic [stcr_pkg::CIDX_W-1:0]  wr_index,
	input  wire logic [stcr_pkg::CDATA_W-1:0] wr_data,
	output stcr_pkg::cfg_t                    cfg
);
	import stcr_pkg::*;

	cfg_t cfg_q;

	// Register writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.function_index  <= '0;
			cfg_q.saved_direction <= 1'b0;
			cfg_q.off_pulse_us    <= OFF_PULSE_RST;
			cfg_q.on_pulse_us     <= ON_PULSE_RST;
			cfg_q.off_step        <= OFF_STEP_RST;
			cfg_q.on_step         <= ON_STEP_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_FUNCTION_INDEX:  cfg_q.function_index  <= wr_data[FIDX_W-1:0];
				REG_SAVED_DIRECTION: cfg_q.saved_direction <= wr_data[0];
				REG_OFF_PULSE_US:    cfg_q.off_pulse_us    <= wr_data[PULSE_W-1:0];
				REG_ON_PULSE_US:     cfg_q.on_pulse_us     <= wr_data[PULSE_W-1:0];
				REG_OFF_STEP:        cfg_q.off_step        <= wr_data[STEP_W-1:0];
				REG_ON_STEP:         cfg_q.on_step         <= wr_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* rtl/stcr_ramp_core.sv */
// Ramp state machine: phase, position and target registers with the per-tick update logic.
// Depends on stcr_pkg.
`default_nettype none

module stcr_ramp_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire stcr_pkg::cfg_t              cfg,
	input  wire logic [stcr_pkg::FUNC_W-1:0] func_bits,
	input  wire logic                        step_en,
	output stcr_pkg::result_t                result
);
	import stcr_pkg::*;

	phase_t             phase_q, phase_d;
	logic [POS_W-1:0]   pos_q, pos_d;
	logic [PULSE_W-1:0] target_q, target_d;
	logic               moving_up_q, moving_up_d;
	logic               attached_q, attached_d;
	logic               led_q, led_d;
	logic               held_q, held_d;
	logic               ramp_on_q, ramp_on_d;

	logic [FUNC_W-1:0]  func_sh;
	logic               func_val;
	logic [PULSE_W-1:0] end_pulse;
	logic [POS_W-1:0]   end_pos;
	logic [POS_W-1:0]   tgt_pos;
	logic [STEP_W-1:0]  step;
	logic [POS_W:0]     up_sum;
	logic [POS_W:0]     dn_diff;
	logic               up_done;
	logic               dn_done;
	logic               done;

	// Function bit select; an out-of-range index keeps the last value
	assign func_sh  = func_bits >> cfg.function_index;
	assign func_val = (cfg.function_index <= FUNC_IDX_MAX) ? func_sh[0] : held_q;

	assign end_pulse = func_val ? cfg.on_pulse_us : cfg.off_pulse_us;
	assign end_pos   = {end_pulse, {FRAC_W{1'b0}}};
	assign tgt_pos   = {target_q, {FRAC_W{1'b0}}};
	assign step      = ramp_on_q ? cfg.on_step : cfg.off_step;

	// Step toward target; a borrow on the way down counts as reaching it
	assign up_sum  = {1'b0, pos_q} + {{(POS_W+1-STEP_W){1'b0}}, step};
	assign dn_diff = {1'b0, pos_q} - {{(POS_W+1-STEP_W){1'b0}}, step};
	assign up_done = up_sum >= {1'b0, tgt_pos};
	assign dn_done = dn_diff[POS_W] || (dn_diff[POS_W-1:0] <= tgt_pos);
	assign done    = moving_up_q ? up_done : dn_done;

	// Next state and result for one tick
	always_comb begin
		phase_d     = phase_q;
		pos_d       = pos_q;
		target_d    = target_q;
		moving_up_d = moving_up_q;
		attached_d  = attached_q;
		led_d       = led_q;
		held_d      = func_val;
		ramp_on_d   = ramp_on_q;

		result.pulse_us    = '0;
		result.pulse_write = 1'b0;
		result.save_event  = 1'b0;
		result.save_value  = 1'b0;

		case (phase_q)
			PH_STANDBY: begin
				led_d = func_val;
				if (func_val == cfg.saved_direction) begin
					// jump straight to the saved end position
					pos_d              = end_pos;
					result.pulse_us    = end_pulse;
					result.pulse_write = 1'b1;
					attached_d         = 1'b0;
					phase_d            = PH_IDLE;
				end else begin
					target_d    = end_pulse;
					ramp_on_d   = func_val;
					moving_up_d = pos_q < end_pos;
					attached_d  = 1'b1;
					phase_d     = PH_RUN;
				end
			end
			PH_IDLE: begin
				if (pos_q != end_pos) begin
					target_d    = end_pulse;
					ramp_on_d   = func_val;
					moving_up_d = pos_q < end_pos;
					attached_d  = 1'b1;
					phase_d     = PH_RUN;
				end
			end
			PH_RUN: begin
				result.pulse_us    = pos_q[POS_W-1:FRAC_W];
				result.pulse_write = 1'b1;
				if (done) begin
					pos_d             = tgt_pos;
					result.pulse_us   = target_q;
					result.save_event = 1'b1;
					result.save_value = ramp_on_q;
					led_d             = ramp_on_q;
					attached_d        = 1'b0;
					phase_d           = PH_IDLE;
				end else if (moving_up_q) begin
					pos_d = up_sum[POS_W-1:0];
				end else begin
					pos_d = dn_diff[POS_W-1:0];
				end
			end
			default: begin
				phase_d = PH_STANDBY;
			end
		endcase

		result.servo_attached = attached_d;
		result.led_on_side    = led_d;
		result.phase          = phase_d;
	end

	// State registers, updated once per processed request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_STANDBY;
			pos_q       <= '0;
			target_q    <= '0;
			moving_up_q <= 1'b0;
			attached_q  <= 1'b0;
			led_q       <= 1'b0;
			held_q      <= 1'b0;
			ramp_on_q   <= 1'b0;
		end else if (step_en) begin
			phase_q     <= phase_d;
			pos_q       <= pos_d;
			target_q    <= target_d;
			moving_up_q <= moving_up_d;
			attached_q  <= attached_d;
			led_q       <= led_d;
			held_q      <= held_d;
			ramp_on_q   <= ramp_on_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/servo_turnout_ramp_controller_top.sv */
// Top level of the servo turnout ramp controller: input register, ramp core, result register.
// Depends on stcr_pkg, stcr_in_if, stcr_out_if, stcr_cfg_regs, stcr_ramp_core.
//
//  channel     dir   payload                                   handshake
//  item_in     in    function_bits[12:0]                       valid/ready
//  result_out  out   pulse_us, pulse_write, servo_attached,    valid/ready
//                    save_event, save_value, led_on_side, phase
//  cfg         in    cfg_index[2:0], cfg_data[15:0]            cfg_wr_en
//
// One request per cycle sustained while result_out is ready; a request is held in the _s1
// register and its result in the result register, which drives result_out.valid.
// The request sits in the _s1 register, the ramp core evaluates it combinationally and its
// state moves when the request passes into the result register.
// A stalled result holds the result register; one more request can wait in _s1.
// Reset puts the ramp in standby with position zero and the config at its defaults.
`default_nettype none

module servo_turnout_ramp_controller_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	stcr_in_if.sink                           item_in,
	stcr_out_if.source                        result_out,
	input  wire logic                         cfg_wr_en,
	input  wire logic [stcr_pkg::CIDX_W-1:0]  cfg_index,
	input  wire logic [stcr_pkg::CDATA_W-1:0] cfg_data
);
	import stcr_pkg::*;

	cfg_t              cfg;
	result_t           core_res;
	logic              valid_s1;
	logic [FUNC_W-1:0] func_bits_s1;
	logic              out_valid_q;
	result_t           res_q;
	logic              advance;

	stcr_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_wr_en),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Request moves into the result register when that slot is free or draining
	assign advance       = valid_s1 && (!out_valid_q || result_out.ready);
	assign item_in.ready = !valid_s1 || advance;

	stcr_ramp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.func_bits (func_bits_s1),
		.step_en   (advance),
		.result    (core_res)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_in.ready) begin
			valid_s1 <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_in.valid && item_in.ready) begin
			func_bits_s1 <= item_in.function_bits;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= core_res;
		end
	end

	assign result_out.valid          = out_valid_q;
	assign result_out.pulse_us       = res_q.pulse_us;
	assign result_out.pulse_write    = res_q.pulse_write;
	assign result_out.servo_attached = res_q.servo_attached;
	assign result_out.save_event     = res_q.save_event;
	assign result_out.save_value     = res_q.save_value;
	assign result_out.led_on_side    = res_q.led_on_side;
	assign result_out.phase          = res_q.phase;

endmodule

`default_nettype wire
